/* hw/rtl/imdu_pkg.sv */
// shared types and constants of the integer multiply / divide unit
// no dependencies; used by the datapath, sequencer, top level and bench by scoped names
package imdu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OPERAND_W      = 32;
  localparam int RESULT_W       = 32;
  localparam int KIND_W         = 3;
  localparam int IN_TDATA_W     = 2 * OPERAND_W;

  // operation selector codes
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SDIV = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SREM = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UDIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UREM = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_A,
    ST_NEG_B,
    ST_RUN,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_NEG_A,
    ALU_NEG_B,
    ALU_MUL_STEP,
    ALU_DIV_STEP,
    ALU_FIX
  } alu_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ACC,
    RES_QUO
  } res_sel_t;

  // request summary seen by the sequencer at accept time
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              a_neg;
    logic              b_neg;
    logic              b_zero;
  } in_info_t;

  // sequencer to datapath control
  typedef struct packed {
    alu_op_t  op;
    logic     fix_neg;
    logic     fix_rem;
    res_sel_t res_sel;
  } alu_ctl_t;

endpackage

/* hw/rtl/imdu_datapath.sv */
// shared adder datapath: operand load, conditional negation, shift-add and restoring steps
// depends on imdu_pkg
module imdu_datapath #(
  parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  imdu_pkg::alu_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] a_in,
  input  logic [DATA_WIDTH-1:0] b_in,
  output logic [DATA_WIDTH-1:0] result
);

  // acc: product or remainder, q: multiplier or dividend/quotient, b: multiplicand or divisor
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;

  logic [DATA_WIDTH:0]   add_x, add_y;
  logic                  add_sub;
  logic [DATA_WIDTH+1:0] add_sum;

  // the one adder / subtractor; carry out set on subtract means no borrow
  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + {{(DATA_WIDTH+1){1'b0}}, add_sub};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    acc_nxt = acc_r;
    q_nxt   = q_r;
    b_nxt   = b_r;
    case (ctl.op)
      imdu_pkg::ALU_LOAD: begin
        acc_nxt = '0;
        q_nxt   = a_in;
        b_nxt   = b_in;
      end
      imdu_pkg::ALU_NEG_A: begin
        add_y   = {1'b0, q_r};
        add_sub = 1'b1;
        if (q_r[DATA_WIDTH-1]) begin
          q_nxt = add_sum[DATA_WIDTH-1:0];
        end
      end
      imdu_pkg::ALU_NEG_B: begin
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
        if (b_r[DATA_WIDTH-1]) begin
          b_nxt = add_sum[DATA_WIDTH-1:0];
        end
      end
      imdu_pkg::ALU_MUL_STEP: begin
        add_x = {1'b0, acc_r};
        add_y = {1'b0, b_r};
        if (q_r[0]) begin
          acc_nxt = add_sum[DATA_WIDTH-1:0];
        end
        b_nxt = {b_r[DATA_WIDTH-2:0], 1'b0};
        q_nxt = {1'b0, q_r[DATA_WIDTH-1:1]};
      end
      imdu_pkg::ALU_DIV_STEP: begin
        add_x   = {acc_r, q_r[DATA_WIDTH-1]};
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
        if (add_sum[DATA_WIDTH+1]) begin
          acc_nxt = add_sum[DATA_WIDTH-1:0];
          q_nxt   = {q_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc_nxt = add_x[DATA_WIDTH-1:0];
          q_nxt   = {q_r[DATA_WIDTH-2:0], 1'b0};
        end
      end
      imdu_pkg::ALU_FIX: begin
        add_y   = ctl.fix_rem ? {1'b0, acc_r} : {1'b0, q_r};
        add_sub = 1'b1;
        if (ctl.fix_neg) begin
          if (ctl.fix_rem) begin
            acc_nxt = add_sum[DATA_WIDTH-1:0];
          end else begin
            q_nxt = add_sum[DATA_WIDTH-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    b_r   <= b_nxt;
  end

  always_comb begin
    case (ctl.res_sel)
      imdu_pkg::RES_ACC: result = acc_r;
      imdu_pkg::RES_QUO: result = q_r;
      default:           result = '0;
    endcase
  end

endmodule

/* hw/rtl/imdu_ctrl.sv */
// sequencer of the multiply / divide unit: state machine, bit counter, output valid
// depends on imdu_pkg
module imdu_ctrl #(
  parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  imdu_pkg::in_info_t  info,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_load,
  output imdu_pkg::alu_ctl_t  ctl
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  imdu_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               is_mul_r, is_mul_nxt;
  logic               is_signed_r, is_signed_nxt;
  logic               neg_q_r, neg_q_nxt;
  logic               neg_r_r, neg_r_nxt;
  imdu_pkg::res_sel_t res_sel_r, res_sel_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               cnt_last;
  logic               out_free;

  assign accept   = (state_r == imdu_pkg::ST_IDLE) && in_valid;
  assign cnt_last = (cnt_r == CNT_W'(DATA_WIDTH - 1));
  assign out_free = !out_valid_r || out_ready;

  // next state and per-request flags
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_mul_nxt    = is_mul_r;
    is_signed_nxt = is_signed_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    res_sel_nxt   = res_sel_r;
    case (state_r)
      imdu_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          is_mul_nxt    = (info.kind == imdu_pkg::KIND_MUL);
          is_signed_nxt = info.kind inside {imdu_pkg::KIND_SDIV, imdu_pkg::KIND_SREM};
          neg_q_nxt     = info.a_neg ^ info.b_neg;
          neg_r_nxt     = info.a_neg;
          if (info.kind == imdu_pkg::KIND_MUL) begin
            res_sel_nxt = imdu_pkg::RES_ACC;
            state_nxt   = imdu_pkg::ST_RUN;
          end else if (info.b_zero ||
                       !(info.kind inside {imdu_pkg::KIND_SDIV, imdu_pkg::KIND_SREM,
                                           imdu_pkg::KIND_UDIV, imdu_pkg::KIND_UREM})) begin
            res_sel_nxt = imdu_pkg::RES_ZERO;
            state_nxt   = imdu_pkg::ST_DONE;
          end else begin
            res_sel_nxt = (info.kind inside {imdu_pkg::KIND_SDIV, imdu_pkg::KIND_UDIV})
                        ? imdu_pkg::RES_QUO : imdu_pkg::RES_ACC;
            state_nxt   = is_signed_nxt ? imdu_pkg::ST_NEG_A : imdu_pkg::ST_RUN;
          end
        end
      end
      imdu_pkg::ST_NEG_A: state_nxt = imdu_pkg::ST_NEG_B;
      imdu_pkg::ST_NEG_B: state_nxt = imdu_pkg::ST_RUN;
      imdu_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = is_signed_r ? imdu_pkg::ST_FIX : imdu_pkg::ST_DONE;
        end
      end
      imdu_pkg::ST_FIX: state_nxt = imdu_pkg::ST_DONE;
      imdu_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = imdu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = imdu_pkg::ST_IDLE;
    endcase
  end

  // outputs toward the datapath and the handshakes
  always_comb begin
    ctl.op      = imdu_pkg::ALU_HOLD;
    ctl.fix_rem = (res_sel_r == imdu_pkg::RES_ACC);
    ctl.fix_neg = (res_sel_r == imdu_pkg::RES_ACC) ? neg_r_r : neg_q_r;
    ctl.res_sel = res_sel_r;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      imdu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.op   = imdu_pkg::ALU_LOAD;
      end
      imdu_pkg::ST_NEG_A: ctl.op = imdu_pkg::ALU_NEG_A;
      imdu_pkg::ST_NEG_B: ctl.op = imdu_pkg::ALU_NEG_B;
      imdu_pkg::ST_RUN:   ctl.op = is_mul_r ? imdu_pkg::ALU_MUL_STEP : imdu_pkg::ALU_DIV_STEP;
      imdu_pkg::ST_FIX:   ctl.op = imdu_pkg::ALU_FIX;
      imdu_pkg::ST_DONE:  out_load = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imdu_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_mul_r    <= is_mul_nxt;
      is_signed_r <= is_signed_nxt;
      neg_q_r     <= neg_q_nxt;
      neg_r_r     <= neg_r_nxt;
      res_sel_r   <= res_sel_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/integer_multiply_divide_unit_top.sv */
// top level of the integer multiply / divide unit
// depends on imdu_pkg, imdu_ctrl and imdu_datapath
//
// usage:
//   input channel in_*: one request carries kind in in_tuser and both operands in
//   in_tdata; a request is taken when in_tvalid and in_tready are high together
//   result channel out_*: one result word per request in out_tdata, taken when
//   out_tvalid and out_tready are high together
//   kinds: multiply low, signed divide, signed remainder, unsigned divide,
//   unsigned remainder; zero divisor and unused kinds give 0
// sequence (one shared adder, one bit per cycle):
//   multiply and unsigned divide and remainder run the bit steps only; signed
//   divide and remainder add two operand negations before them and one sign fix
//   after; a divide by a zero divisor or an unused kind goes straight to the result
//   in_tready is high only while the sequencer idles, so a new request is taken
//   only once the previous result has moved into the output register
// stall: a finished result sits in the output register; while it waits the unit
//   takes and works on the next request, which holds in its last step until the
//   output register is free
// reset: rst_n synchronous active low; clears the sequencer state and bit counter, and out_tvalid
module integer_multiply_divide_unit_top #(
  parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] operand_a, [63:32] operand_b
  input  logic [imdu_pkg::IN_TDATA_W-1:0] in_tdata,
  // [2:0] kind
  input  logic [imdu_pkg::KIND_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] result
  output logic [imdu_pkg::RESULT_W-1:0]   out_tdata
);

  // operands at the datapath width: low bits kept, or zero extended
  logic [DATA_WIDTH-1:0]         a_ext;
  logic [DATA_WIDTH-1:0]         b_ext;
  logic [DATA_WIDTH-1:0]         dp_result;
  imdu_pkg::in_info_t            info;
  imdu_pkg::alu_ctl_t            ctl;
  logic                          out_load;
  logic [imdu_pkg::RESULT_W-1:0] out_tdata_r;

  assign a_ext = DATA_WIDTH'(in_tdata[imdu_pkg::OPERAND_W-1:0]);
  assign b_ext = DATA_WIDTH'(in_tdata[imdu_pkg::IN_TDATA_W-1:imdu_pkg::OPERAND_W]);

  // request summary for the sequencer
  assign info.kind   = in_tuser;
  assign info.a_neg  = a_ext[DATA_WIDTH-1];
  assign info.b_neg  = b_ext[DATA_WIDTH-1];
  assign info.b_zero = (b_ext == '0);

  imdu_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .info      (info),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_load  (out_load),
    .ctl       (ctl)
  );

  imdu_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .ctl    (ctl),
    .a_in   (a_ext),
    .b_in   (b_ext),
    .result (dp_result)
  );

  // output register, loaded when the finished result moves out
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= imdu_pkg::RESULT_W'(dp_result);
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

/* hw/rtl/imdu_checker.sv */
// port-level assertions for the multiply / divide unit, bound to the top level
// depends on integer_multiply_divide_unit_top
module imdu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a new result only appears after a busy cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without work");

  // reset leaves the unit idle with no result
  assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("unit not idle after reset");

endmodule

bind integer_multiply_divide_unit_top imdu_checker u_imdu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_integer_multiply_divide_unit_top.sv */
// self-checking bench for integer_multiply_divide_unit_top: directed table, then random requests
// depends on imdu_pkg and the top level; expected words come from typed rows or the behavioral predictor below
module tb_integer_multiply_divide_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  // widths and selector codes taken from the package
  localparam int KIND_W     = imdu_pkg::KIND_W;
  localparam int OPERAND_W  = imdu_pkg::OPERAND_W;
  localparam int RESULT_W   = imdu_pkg::RESULT_W;
  localparam int IN_TDATA_W = imdu_pkg::IN_TDATA_W;

  localparam logic [KIND_W-1:0] KIND_MUL  = imdu_pkg::KIND_MUL;
  localparam logic [KIND_W-1:0] KIND_SDIV = imdu_pkg::KIND_SDIV;
  localparam logic [KIND_W-1:0] KIND_SREM = imdu_pkg::KIND_SREM;
  localparam logic [KIND_W-1:0] KIND_UDIV = imdu_pkg::KIND_UDIV;
  localparam logic [KIND_W-1:0] KIND_UREM = imdu_pkg::KIND_UREM;

  // selector codes the block leaves unused, all give a zero result
  localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  localparam logic [OPERAND_W-1:0] MOST_NEG = {1'b1, {(OPERAND_W-1){1'b0}}};
  localparam logic [OPERAND_W-1:0] MOST_POS = {1'b0, {(OPERAND_W-1){1'b1}}};
  localparam logic [OPERAND_W-1:0] ALL_ONES = '1;

  localparam bit CHECK_TYPED = 1'b1;   // row carries its own expected word
  localparam bit CHECK_MODEL = 1'b0;   // row is checked against the predictor

  localparam int RANDOM_ITEMS   = 1000;
  localparam int SQUEEZE_AT     = 200;   // random request at which the sink holds off
  localparam int SQUEEZE_CYCLES = 400;
  localparam int TAIL_CYCLES    = 2 * OPERAND_W;
  // worst case per request: work, the longest idle on the input and the longest stall
  // on the output; about 1022 requests plus the hold-off, taken several times over
  localparam int CYCLE_LIMIT    = 600000;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
    bit                   typed;
    logic [RESULT_W-1:0]  result;
  } mdu_row_t;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
    logic [RESULT_W-1:0]  result;
  } mdu_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RESULT_W-1:0]   out_tdata;

  mdu_req_t    owed_results[$];
  mdu_row_t    directed_rows[22];
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  bit          squeeze_start = 1'b0;
  bit          squeeze_done  = 1'b0;

  integer_multiply_divide_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] operand_a, [63:32] operand_b
    .in_tuser   (in_tuser),     // [2:0] kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // [31:0] result
  );

  always #6 clk = ~clk;

  // product low word, truncating signed quotient and remainder, unsigned quotient
  // and remainder; zero divisor and spare selectors give zero
  function automatic logic [RESULT_W-1:0] arith_result(input logic [KIND_W-1:0] kind,
                                                       input logic [OPERAND_W-1:0] a,
                                                       input logic [OPERAND_W-1:0] b);
    logic [OPERAND_W-1:0] mag_a;
    logic [OPERAND_W-1:0] mag_b;
    logic [OPERAND_W-1:0] quo;
    logic [OPERAND_W-1:0] res;
    res = '0;
    quo = '0;
    mag_a = a[OPERAND_W-1] ? -a : a;
    mag_b = b[OPERAND_W-1] ? -b : b;
    if (b != '0) begin
      quo = mag_a / mag_b;
      if (a[OPERAND_W-1] ^ b[OPERAND_W-1]) quo = -quo;
    end
    case (kind)
      KIND_MUL:  res = a * b;
      KIND_SDIV: res = quo;
      KIND_SREM: if (b != '0) res = a - quo * b;
      KIND_UDIV: if (b != '0) res = a / b;
      KIND_UREM: if (b != '0) res = a % b;
      default:   res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return KIND_MUL;
    if (r < 36) return KIND_SDIV;
    if (r < 54) return KIND_SREM;
    if (r < 72) return KIND_UDIV;
    if (r < 90) return KIND_UREM;
    if (r < 94) return KIND_SPARE5;
    if (r < 97) return KIND_SPARE6;
    return KIND_SPARE7;
  endfunction

  // full range, tiny values, the extremes, and short magnitudes of either sign
  function automatic logic [OPERAND_W-1:0] pick_operand();
    int unsigned r;
    logic [OPERAND_W-1:0] v;
    r = $urandom_range(0, 99);
    v = $urandom;
    if (r < 45) return v;
    if (r < 60) return $urandom_range(0, 15);
    if (r < 75) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return 1;
        2:       return ALL_ONES;
        3:       return MOST_NEG;
        default: return MOST_POS;
      endcase
    end
    v = v >> $urandom_range(1, OPERAND_W - 1);
    if (r < 90) return v;
    return -v;
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int unsigned idle_length(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input mdu_req_t req);
    $display("mismatch at cycle %0d: %s (kind %0d a %h b %h got %h want %h)",
             cycle_count, what, req.kind, req.a, req.b, out_tdata, req.result);
    mismatches++;
  endtask

  // offers one request and returns at the edge that takes it; in_tvalid stays
  // high afterwards so back-to-back requests need no extra edge
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [OPERAND_W-1:0] a,
                              input logic [OPERAND_W-1:0] b, input logic [RESULT_W-1:0] want);
    int unsigned gap;
    mdu_req_t    req;
    gap = idle_length(((requests_sent / 64) % 4 == 1) || (squeeze_start && !squeeze_done));
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    req.kind   = kind;
    req.a      = a;
    req.b      = b;
    req.result = want;
    owed_results.push_back(req);
    requests_sent++;
  endtask

  // result sink: random stalls, calm stretches, and one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (squeeze_start && !squeeze_done) begin
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
        out_tready <= 1'b1;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          stall_left = idle_length((results_seen / 64) % 4 == 3);
      end
    end
  end

  always @(posedge clk) begin : result_check
    mdu_req_t req;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        req = '{kind: '0, a: '0, b: '0, result: 'x};
        report_mismatch("result with no request outstanding", req);
      end else begin
        req = owed_results.pop_front();
        if (out_tdata !== req.result) report_mismatch("wrong result", req);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_multiply_divide_unit_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KIND_W-1:0]    kind;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
    mdu_req_t             req;

    directed_rows = '{
      '{KIND_MUL,    ALL_ONES,       ALL_ONES,       CHECK_TYPED, 32'h0000_0001},
      '{KIND_MUL,    MOST_NEG,       32'h0000_0002,  CHECK_TYPED, 32'h0000_0000},
      '{KIND_MUL,    32'h0000_0000,  ALL_ONES,       CHECK_TYPED, 32'h0000_0000},
      '{KIND_MUL,    32'h1234_5678,  32'h9abc_def0,  CHECK_MODEL, 32'h0},
      // most negative over minus one wraps, remainder zero
      '{KIND_SDIV,   MOST_NEG,       ALL_ONES,       CHECK_TYPED, MOST_NEG},
      '{KIND_SREM,   MOST_NEG,       ALL_ONES,       CHECK_TYPED, 32'h0000_0000},
      // zero divisor gives zero on every divide kind
      '{KIND_SDIV,   MOST_POS,       32'h0000_0000,  CHECK_TYPED, 32'h0000_0000},
      '{KIND_SREM,   MOST_NEG,       32'h0000_0000,  CHECK_TYPED, 32'h0000_0000},
      '{KIND_UDIV,   ALL_ONES,       32'h0000_0000,  CHECK_TYPED, 32'h0000_0000},
      '{KIND_UREM,   ALL_ONES,       32'h0000_0000,  CHECK_TYPED, 32'h0000_0000},
      '{KIND_UREM,   32'h0000_0000,  32'h0000_0000,  CHECK_TYPED, 32'h0000_0000},
      // truncation toward zero, remainder follows the dividend
      '{KIND_SDIV,   32'hffff_fff9,  32'h0000_0002,  CHECK_TYPED, 32'hffff_fffd},
      '{KIND_SREM,   32'hffff_fff9,  32'h0000_0002,  CHECK_TYPED, 32'hffff_ffff},
      '{KIND_SDIV,   32'h0000_0007,  32'hffff_fffe,  CHECK_TYPED, 32'hffff_fffd},
      '{KIND_SREM,   32'h0000_0007,  32'hffff_fffe,  CHECK_TYPED, 32'h0000_0001},
      '{KIND_SDIV,   MOST_POS,       MOST_NEG,       CHECK_MODEL, 32'h0},
      '{KIND_SDIV,   MOST_NEG,       MOST_NEG,       CHECK_MODEL, 32'h0},
      '{KIND_UDIV,   ALL_ONES,       32'h0000_0001,  CHECK_TYPED, ALL_ONES},
      '{KIND_UREM,   ALL_ONES,       32'h0000_0010,  CHECK_TYPED, 32'h0000_000f},
      '{KIND_UDIV,   MOST_NEG,       ALL_ONES,       CHECK_MODEL, 32'h0},
      // spare selectors
      '{KIND_SPARE5, ALL_ONES,       ALL_ONES,       CHECK_TYPED, 32'h0000_0000},
      '{KIND_SPARE7, MOST_NEG,       32'h0000_0000,  CHECK_TYPED, 32'h0000_0000}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].typed ? directed_rows[i].result
                                          : arith_result(directed_rows[i].kind,
                                                         directed_rows[i].a,
                                                         directed_rows[i].b));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == SQUEEZE_AT) squeeze_start = 1'b1;
      kind = pick_kind();
      a    = pick_operand();
      b    = pick_operand();
      if ($urandom_range(0, 19) == 0) b = '0;
      if (kind == KIND_SPARE6 && $urandom_range(0, 1) == 0) a = ALL_ONES;
      send_request(kind, a, b, arith_result(kind, a, b));
    end
    in_tvalid <= 1'b0;

    wait (owed_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (owed_results.size() != 0) begin
      req = owed_results.pop_front();
      report_mismatch("result never arrived", req);
    end

    if (mismatches == 0) begin
      $display("integer_multiply_divide_unit_top regression: pass");
    end else begin
      $display("integer_multiply_divide_unit_top regression: fail");
    end
    $finish;
  end

endmodule
